/* rtl/core/ausm_pkg.sv */
package ausm_pkg;

  localparam int VALUE_WIDTH_DEF = 48;
  localparam int FRAC = 16;

  localparam logic SPLIT_LINEAR = 1'b0;
  localparam logic SPLIT_QUAD   = 1'b1;

endpackage

/* rtl/core/ausm_div.sv */
module ausm_div #(
  parameter int W      = ausm_pkg::VALUE_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_u_l,
  input  logic [W-2:0]        in_a_l,
  input  logic signed [W-1:0] in_u_r,
  input  logic [W-2:0]        in_a_r,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [W-1:0] out_mach_l,
  output logic signed [W-1:0] out_mach_r,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int F  = ausm_pkg::FRAC;
  localparam int UW = W - 1;
  localparam int RW = W + F;
  localparam int DW = 2 * W;

  logic [RW-1:0]     rem_r  [0:1][0:W-1];
  logic [UW-1:0]     den_r  [0:1][0:W-1];
  logic [UW-1:0]     quo_r  [0:1][0:W-1];
  logic              neg_r  [0:1][0:W-1];
  logic              sat_r  [0:1][0:W-1];
  logic              vld_r  [0:W-1];
  logic [SIDE_W-1:0] side_r [0:W-1];

  logic signed [W-1:0] u_in [0:1];
  logic [UW-1:0]       a_in [0:1];
  logic signed [W-1:0] mach [0:1];

  assign u_in[0] = in_u_l;
  assign u_in[1] = in_u_r;
  assign a_in[0] = in_a_l;
  assign a_in[1] = in_a_r;

  // entry: magnitude, divisor with zero forced to one lsb, overflow check
  for (genvar l = 0; l < 2; l++) begin : g_entry
    logic [W-1:0]  mag;
    logic [UW-1:0] a0;
    logic [RW-1:0] num;
    logic          sat_nxt;
    always_comb begin
      mag = u_in[l][W-1] ? (~u_in[l] + 1'b1) : u_in[l];
      a0 = (a_in[l] == '0) ? UW'(1) : a_in[l];
      num = {mag, {F{1'b0}}};
      sat_nxt = {{(DW-RW){1'b0}}, num} >= ({{(DW-UW){1'b0}}, a0} << (W - 1));
    end
    always_ff @(posedge clk) begin
      rem_r[l][0] <= num;
      den_r[l][0] <= a0;
      quo_r[l][0] <= '0;
      neg_r[l][0] <= u_in[l][W-1];
      sat_r[l][0] <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k < W; k++) begin : g_step
    localparam int B = W - 1 - k;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW-1:0] dsh;
      logic [DW-1:0] rext;
      logic [DW-1:0] diff;
      logic          ge;
      logic [RW-1:0] rem_nxt;
      logic [UW-1:0] quo_nxt;
      always_comb begin
        dsh = {{(DW-UW){1'b0}}, den_r[l][k-1]} << B;
        rext = {{(DW-RW){1'b0}}, rem_r[l][k-1]};
        ge = rext >= dsh;
        diff = rext - dsh;
        rem_nxt = ge ? diff[RW-1:0] : rem_r[l][k-1];
        quo_nxt = quo_r[l][k-1];
        quo_nxt[B] = ge;
      end
      always_ff @(posedge clk) begin
        rem_r[l][k] <= rem_nxt;
        den_r[l][k] <= den_r[l][k-1];
        quo_r[l][k] <= quo_nxt;
        neg_r[l][k] <= neg_r[l][k-1];
        sat_r[l][k] <= sat_r[l][k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_out
    logic [W-1:0] qm;
    always_comb begin
      qm = sat_r[l][W-1] ? {1'b0, {UW{1'b1}}} : {1'b0, quo_r[l][W-1]};
      mach[l] = neg_r[l][W-1] ? $signed(~qm + 1'b1) : $signed(qm);
    end
  end

  assign out_valid  = vld_r[W-1];
  assign out_mach_l = mach[0];
  assign out_mach_r = mach[1];
  assign out_side   = side_r[W-1];

endmodule

/* rtl/core/ausm_interface_flux_top.sv */
// AUSM flux splitting at one cell face.
// input channel: the left and right states (normal and transverse velocities,
// sound speed, pressure, density) are taken at an edge where start is high
// and busy is low. busy is always low, so a new item may come every cycle.
// result channel: out_strobe is high for one cycle with the interface
// velocity, split pressure, upwind density, sound speed and transverse
// velocities, the two wave speeds and the upwind flag. the receiver cannot
// stall, and results come in the order the items went in.
// an entry register forms the Mach divisor and overflow check, the
// bit-per-stage Mach dividers follow, then the stages of splitting
// polynomials and split multipliers. throughput is one item per cycle.
// cfg_we writes cfg_wdata into the pressure split order (0 linear,
// 1 second order); write it only while no item is in flight.
// reset clears the pipeline valid bits and sets linear splitting.
module ausm_interface_flux_top #(
  parameter int VALUE_WIDTH = ausm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_left_normal_velocity,
  input  logic signed [VALUE_WIDTH-1:0] in_left_tangential_v,
  input  logic signed [VALUE_WIDTH-1:0] in_left_tangential_w,
  input  logic [VALUE_WIDTH-2:0]        in_left_sound_speed,
  input  logic [VALUE_WIDTH-2:0]        in_left_pressure,
  input  logic [VALUE_WIDTH-2:0]        in_left_density,
  input  logic signed [VALUE_WIDTH-1:0] in_right_normal_velocity,
  input  logic signed [VALUE_WIDTH-1:0] in_right_tangential_v,
  input  logic signed [VALUE_WIDTH-1:0] in_right_tangential_w,
  input  logic [VALUE_WIDTH-2:0]        in_right_sound_speed,
  input  logic [VALUE_WIDTH-2:0]        in_right_pressure,
  input  logic [VALUE_WIDTH-2:0]        in_right_density,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  output logic                          out_strobe,
  output logic signed [VALUE_WIDTH-1:0] out_interface_velocity,
  output logic signed [VALUE_WIDTH-1:0] out_interface_pressure,
  output logic [VALUE_WIDTH-2:0]        out_interface_density,
  output logic [VALUE_WIDTH-2:0]        out_interface_sound_speed,
  output logic signed [VALUE_WIDTH-1:0] out_interface_tangential_v,
  output logic signed [VALUE_WIDTH-1:0] out_interface_tangential_w,
  output logic signed [VALUE_WIDTH-1:0] out_left_wave_speed,
  output logic signed [VALUE_WIDTH-1:0] out_right_wave_speed,
  output logic                          out_upwind_is_right
);

  localparam int W   = VALUE_WIDTH;
  localparam int UW  = W - 1;
  localparam int F   = ausm_pkg::FRAC;
  localparam int SW  = F + 2;
  localparam int SQW = 2 * SW;
  localparam int YW  = 3 * F + 3;
  localparam int PSH = 3 * F + 2;
  localparam int PL  = UW / 2;
  localparam int PHW = UW - PL;
  localparam int YL  = YW / 2;
  localparam int YHW = YW - YL;
  localparam int ML  = W / 2;
  localparam int MHW = W - ML;
  localparam int PRW = UW + YW;
  localparam int ARW = UW + W;

  localparam int O_RWS = 0;
  localparam int O_LWS = W;
  localparam int O_RR  = 2 * W;
  localparam int O_PR  = 2 * W + UW;
  localparam int O_AR  = 2 * W + 2 * UW;
  localparam int O_WR  = 2 * W + 3 * UW;
  localparam int O_VR  = 3 * W + 3 * UW;
  localparam int O_RL  = 4 * W + 3 * UW;
  localparam int O_PL  = 4 * W + 4 * UW;
  localparam int O_AL  = 4 * W + 5 * UW;
  localparam int O_WL  = 4 * W + 6 * UW;
  localparam int O_VL  = 5 * W + 6 * UW;
  localparam int SDW   = 6 * W + 6 * UW;

  localparam int C_RWS = 0;
  localparam int C_LWS = W;
  localparam int C_W   = 2 * W;
  localparam int C_V   = 3 * W;
  localparam int C_SND = 4 * W;
  localparam int C_RHO = 4 * W + UW;
  localparam int CW    = 4 * W + 2 * UW;

  localparam logic signed [W-1:0] ONE_S  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0] MONE_S = -ONE_S;
  localparam logic signed [W-1:0] TWO_S  = {{(W-F-2){1'b0}}, 1'b1, {(F+1){1'b0}}};
  localparam logic [UW-1:0]       VMAXU  = {UW{1'b1}};

  logic order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ausm_pkg::SPLIT_LINEAR;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // wave speeds at the input, saturated
  logic [W:0]     lws_x, rws_x;
  logic [W-1:0]   lws, rws;
  logic [SDW-1:0] side_in;

  always_comb begin
    lws_x = {in_left_normal_velocity[W-1], in_left_normal_velocity}
            - {2'b00, in_left_sound_speed};
    rws_x = {in_right_normal_velocity[W-1], in_right_normal_velocity}
            + {2'b00, in_right_sound_speed};
    lws = (lws_x[W] != lws_x[W-1]) ? {lws_x[W], {UW{~lws_x[W]}}} : lws_x[W-1:0];
    rws = (rws_x[W] != rws_x[W-1]) ? {rws_x[W], {UW{~rws_x[W]}}} : rws_x[W-1:0];
    side_in = {in_left_tangential_v,
               in_left_tangential_w, in_left_sound_speed, in_left_pressure,
               in_left_density, in_right_tangential_v, in_right_tangential_w,
               in_right_sound_speed, in_right_pressure, in_right_density, lws, rws};
  end

  logic                div_v;
  logic signed [W-1:0] ml, mr;
  logic [SDW-1:0]      div_side;

  ausm_div #(
    .W      (W),
    .SIDE_W (SDW)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_u_l     (in_left_normal_velocity),
    .in_a_l     (in_left_sound_speed),
    .in_u_r     (in_right_normal_velocity),
    .in_a_r     (in_right_sound_speed),
    .in_side    (side_in),
    .out_valid  (div_v),
    .out_mach_l (ml),
    .out_mach_r (mr),
    .out_side   (div_side)
  );

  // stage 1: clip and split factors
  logic                s1_v_r, s1_gtl_r, s1_gtr_r, s1_ltr_r;
  logic signed [W-1:0] s1_ml_r, s1_mr_r;
  logic [SW-1:0]       s1_sp_r, s1_tp_r, s1_sm_r, s1_tm_r;
  logic [SDW-1:0]      s1_side_r;
  logic signed [W-1:0] mlc, mrc, sp_w, tp_w, sm_w, tm_w;

  always_comb begin
    mlc = (ml > ONE_S) ? ONE_S : ((ml < MONE_S) ? MONE_S : ml);
    mrc = (mr > ONE_S) ? ONE_S : ((mr < MONE_S) ? MONE_S : mr);
    sp_w = ONE_S + mlc;
    tp_w = TWO_S - mlc;
    sm_w = ONE_S - mrc;
    tm_w = TWO_S + mrc;
  end

  always_ff @(posedge clk) begin
    s1_gtl_r  <= ml > ONE_S;
    s1_gtr_r  <= mr > ONE_S;
    s1_ltr_r  <= mr < MONE_S;
    s1_ml_r   <= ml;
    s1_mr_r   <= mr;
    s1_sp_r   <= sp_w[SW-1:0];
    s1_tp_r   <= tp_w[SW-1:0];
    s1_sm_r   <= sm_w[SW-1:0];
    s1_tm_r   <= tm_w[SW-1:0];
    s1_side_r <= div_side;
  end

  // stage 2: squares
  logic                s2_v_r, s2_gtl_r, s2_gtr_r, s2_ltr_r;
  logic signed [W-1:0] s2_ml_r, s2_mr_r;
  logic [SW-1:0]       s2_sp_r, s2_tp_r, s2_sm_r, s2_tm_r;
  logic [SQW-1:0]      s2_sql_r, s2_sqr_r;
  logic [SDW-1:0]      s2_side_r;

  always_ff @(posedge clk) begin
    s2_gtl_r  <= s1_gtl_r;
    s2_gtr_r  <= s1_gtr_r;
    s2_ltr_r  <= s1_ltr_r;
    s2_ml_r   <= s1_ml_r;
    s2_mr_r   <= s1_mr_r;
    s2_sp_r   <= s1_sp_r;
    s2_tp_r   <= s1_tp_r;
    s2_sm_r   <= s1_sm_r;
    s2_tm_r   <= s1_tm_r;
    s2_sql_r  <= s1_sp_r * s1_sp_r;
    s2_sqr_r  <= s1_sm_r * s1_sm_r;
    s2_side_r <= s1_side_r;
  end

  // stage 3: split Mach sum and pressure factors
  logic                s3_v_r;
  logic signed [W:0]   s3_mh_r;
  logic [YW-1:0]       s3_yl_r, s3_yr_r;
  logic [SDW-1:0]      s3_side_r;
  logic signed [W-1:0] mlp, mrm;
  logic signed [W:0]   mh_nxt;
  logic [3*SW-1:0]     ql, qr;
  logic [YW-1:0]       yl_nxt, yr_nxt;

  always_comb begin
    mlp = s2_gtl_r ? s2_ml_r : $signed(W'(s2_sql_r >> (F + 2)));
    if (s2_gtr_r) begin
      mrm = '0;
    end else if (s2_ltr_r) begin
      mrm = s2_mr_r;
    end else begin
      mrm = -$signed(W'(s2_sqr_r >> (F + 2)));
    end
    mh_nxt = $signed({mlp[W-1], mlp}) + $signed({mrm[W-1], mrm});
    ql = s2_sql_r * s2_tp_r;
    qr = s2_sqr_r * s2_tm_r;
    yl_nxt = (order_r == ausm_pkg::SPLIT_QUAD) ? ql[YW-1:0] : {s2_sp_r, {(2*F+1){1'b0}}};
    yr_nxt = (order_r == ausm_pkg::SPLIT_QUAD) ? qr[YW-1:0] : {s2_sm_r, {(2*F+1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    s3_mh_r   <= mh_nxt;
    s3_yl_r   <= yl_nxt;
    s3_yr_r   <= yr_nxt;
    s3_side_r <= s2_side_r;
  end

  // stage 4: upwind choice, pressure partial products
  logic                 s4_v_r, s4_right_r;
  logic [W-1:0]         s4_mag_r;
  logic [UW-1:0]        s4_aup_r;
  logic [CW-1:0]        s4_carry_r;
  logic [PL+YL-1:0]     s4_pll_r, s4_rll_r;
  logic [PL+YHW-1:0]    s4_plh_r, s4_rlh_r;
  logic [PHW+YL-1:0]    s4_phl_r, s4_rhl_r;
  logic [PHW+YHW-1:0]   s4_phh_r, s4_rhh_r;
  logic                 right;
  logic [W:0]           mag_x;
  logic [UW-1:0]        aup, p_l, p_r;
  logic [CW-1:0]        carry_nxt;

  always_comb begin
    right = s3_mh_r[W];
    mag_x = right ? (~s3_mh_r + 1'b1) : s3_mh_r;
    aup = right ? s3_side_r[O_AR +: UW] : s3_side_r[O_AL +: UW];
    if (aup == '0) begin
      aup = UW'(1);
    end
    p_l = s3_side_r[O_PL +: UW];
    p_r = s3_side_r[O_PR +: UW];
    carry_nxt = {right ? s3_side_r[O_RR +: UW] : s3_side_r[O_RL +: UW],
                 right ? s3_side_r[O_AR +: UW] : s3_side_r[O_AL +: UW],
                 right ? s3_side_r[O_VR +: W]  : s3_side_r[O_VL +: W],
                 right ? s3_side_r[O_WR +: W]  : s3_side_r[O_WL +: W],
                 s3_side_r[O_LWS +: W], s3_side_r[O_RWS +: W]};
  end

  always_ff @(posedge clk) begin
    s4_right_r <= right;
    s4_mag_r   <= mag_x[W-1:0];
    s4_aup_r   <= aup;
    s4_carry_r <= carry_nxt;
    s4_pll_r   <= p_l[PL-1:0] * s3_yl_r[YL-1:0];
    s4_plh_r   <= p_l[PL-1:0] * s3_yl_r[YW-1:YL];
    s4_phl_r   <= p_l[UW-1:PL] * s3_yl_r[YL-1:0];
    s4_phh_r   <= p_l[UW-1:PL] * s3_yl_r[YW-1:YL];
    s4_rll_r   <= p_r[PL-1:0] * s3_yr_r[YL-1:0];
    s4_rlh_r   <= p_r[PL-1:0] * s3_yr_r[YW-1:YL];
    s4_rhl_r   <= p_r[UW-1:PL] * s3_yr_r[YL-1:0];
    s4_rhh_r   <= p_r[UW-1:PL] * s3_yr_r[YW-1:YL];
  end

  // stage 5: pressure sums, advection partial products
  logic                 s5_v_r, s5_right_r;
  logic [UW-1:0]        s5_pp_r, s5_pm_r;
  logic [CW-1:0]        s5_carry_r;
  logic [PL+ML-1:0]     s5_all_r;
  logic [PL+MHW-1:0]    s5_alh_r;
  logic [PHW+ML-1:0]    s5_ahl_r;
  logic [PHW+MHW-1:0]   s5_ahh_r;
  logic [PRW-1:0]       psum_l, psum_r, psh_l, psh_r;
  logic [UW-1:0]        pp_nxt, pm_nxt;

  always_comb begin
    psum_l = PRW'(s4_pll_r) + (PRW'(s4_plh_r) << YL) + (PRW'(s4_phl_r) << PL)
             + (PRW'(s4_phh_r) << (PL + YL));
    psum_r = PRW'(s4_rll_r) + (PRW'(s4_rlh_r) << YL) + (PRW'(s4_rhl_r) << PL)
             + (PRW'(s4_rhh_r) << (PL + YL));
    psh_l = psum_l >> PSH;
    psh_r = psum_r >> PSH;
    pp_nxt = (psh_l > PRW'(VMAXU)) ? VMAXU : psh_l[UW-1:0];
    pm_nxt = (psh_r > PRW'(VMAXU)) ? VMAXU : psh_r[UW-1:0];
  end

  always_ff @(posedge clk) begin
    s5_right_r <= s4_right_r;
    s5_pp_r    <= pp_nxt;
    s5_pm_r    <= pm_nxt;
    s5_carry_r <= s4_carry_r;
    s5_all_r   <= s4_aup_r[PL-1:0] * s4_mag_r[ML-1:0];
    s5_alh_r   <= s4_aup_r[PL-1:0] * s4_mag_r[W-1:ML];
    s5_ahl_r   <= s4_aup_r[UW-1:PL] * s4_mag_r[ML-1:0];
    s5_ahh_r   <= s4_aup_r[UW-1:PL] * s4_mag_r[W-1:ML];
  end

  // stage 6: advective speed and interface pressure
  logic                s6_v_r, s6_right_r;
  logic signed [W-1:0] s6_adv_r, s6_ph_r;
  logic [CW-1:0]       s6_carry_r;
  logic [ARW-1:0]      asum, ash, alim, advm;
  logic [W-1:0]        adv_nxt;
  logic [UW:0]         ph_x;
  logic [W-1:0]        ph_nxt;

  always_comb begin
    asum = ARW'(s5_all_r) + (ARW'(s5_alh_r) << ML) + (ARW'(s5_ahl_r) << PL)
           + (ARW'(s5_ahh_r) << (PL + ML));
    ash = asum >> F;
    // a negative speed may reach one lsb further than a positive one
    alim = s5_right_r ? ARW'({1'b1, {UW{1'b0}}}) : ARW'(VMAXU);
    advm = (ash > alim) ? alim : ash;
    adv_nxt = s5_right_r ? (~advm[W-1:0] + 1'b1) : advm[W-1:0];
    ph_x = {1'b0, s5_pp_r} + {1'b0, s5_pm_r};
    ph_nxt = ph_x[UW] ? {1'b0, VMAXU} : {1'b0, ph_x[UW-1:0]};
  end

  always_ff @(posedge clk) begin
    s6_right_r <= s5_right_r;
    s6_adv_r   <= $signed(adv_nxt);
    s6_ph_r    <= $signed(ph_nxt);
    s6_carry_r <= s5_carry_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      s1_v_r <= div_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  assign out_strobe                 = s6_v_r;
  assign out_interface_velocity     = s6_adv_r;
  assign out_interface_pressure     = s6_ph_r;
  assign out_interface_density      = s6_carry_r[C_RHO +: UW];
  assign out_interface_sound_speed  = s6_carry_r[C_SND +: UW];
  assign out_interface_tangential_v = $signed(s6_carry_r[C_V +: W]);
  assign out_interface_tangential_w = $signed(s6_carry_r[C_W +: W]);
  assign out_left_wave_speed        = $signed(s6_carry_r[C_LWS +: W]);
  assign out_right_wave_speed       = $signed(s6_carry_r[C_RWS +: W]);
  assign out_upwind_is_right        = s6_right_r;

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 48;
  localparam int PIPE_LAT = W + 6;
  localparam longint ONE = longint'(1) << ausm_pkg::FRAC;
  localparam longint UMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint SMIN = -(longint'(1) << (W - 1));
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [W-1:0] ul, vl, wl;
    logic [W-2:0]        al, pl, rl;
    logic signed [W-1:0] ur, vr, wr;
    logic [W-2:0]        ar, pr, rr;
  } face_t;

  typedef struct {
    logic signed [W-1:0] vel, pres;
    logic [W-2:0]        dens, snd;
    logic signed [W-1:0] tv, tw, lws, rws;
    logic                upr;
  } flux_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  face_t drv = '{default: '0};
  flux_t got;
  logic out_strobe;

  flux_t flux_q[$];
  logic split_order = ausm_pkg::SPLIT_LINEAR;
  int errors = 0;
  int n_items = 0;
  int n_quad = 0;
  int n_checked = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  always #1 clk = ~clk;

  ausm_interface_flux_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_left_normal_velocity(drv.ul), .in_left_tangential_v(drv.vl),
    .in_left_tangential_w(drv.wl), .in_left_sound_speed(drv.al),
    .in_left_pressure(drv.pl), .in_left_density(drv.rl),
    .in_right_normal_velocity(drv.ur), .in_right_tangential_v(drv.vr),
    .in_right_tangential_w(drv.wr), .in_right_sound_speed(drv.ar),
    .in_right_pressure(drv.pr), .in_right_density(drv.rr),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe),
    .out_interface_velocity(got.vel), .out_interface_pressure(got.pres),
    .out_interface_density(got.dens), .out_interface_sound_speed(got.snd),
    .out_interface_tangential_v(got.tv), .out_interface_tangential_w(got.tw),
    .out_left_wave_speed(got.lws), .out_right_wave_speed(got.rws),
    .out_upwind_is_right(got.upr)
  );

  function automatic longint mach_of(longint u, logic [W-2:0] a);
    logic [127:0] q;
    longint unsigned mag;
    longint unsigned den;
    mag = (u < 0) ? longint'(-u) : u;
    den = (a == 0) ? 1 : a;
    q = ({64'd0, mag} << ausm_pkg::FRAC) / {64'd0, den};
    if (q > UMAX) q = UMAX;
    return (u < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clip_unit(longint m);
    if (m > ONE) return ONE;
    if (m < -ONE) return -ONE;
    return m;
  endfunction

  // (x * y) >> sh, clamped
  function automatic longint unsigned mul_shift(longint unsigned x, longint unsigned y,
                                                int sh, longint unsigned lim);
    logic [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) >> sh;
    return (p > lim) ? lim : p[63:0];
  endfunction

  function automatic longint clamp_s(longint v);
    if (v > UMAX) return UMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic flux_t ausm_flux(face_t f, logic order);
    flux_t r;
    longint ul, ur, ml, mr, mlp, mrm, msum, mlc, mrc, s, t, s2, t2;
    longint unsigned aup, mag, adv, pp, pm, ph;
    bit right;
    ul = f.ul;
    ur = f.ur;
    ml = mach_of(ul, f.al);
    mr = mach_of(ur, f.ar);
    if (ml > ONE) mlp = ml;
    else if (ml > -ONE) begin
      s = ml + ONE;
      mlp = (s * s) >>> (ausm_pkg::FRAC + 2);
    end else mlp = 0;
    if (mr > ONE) mrm = 0;
    else if (mr > -ONE) begin
      s = ONE - mr;
      mrm = -((s * s) >>> (ausm_pkg::FRAC + 2));
    end else mrm = mr;
    msum = mlp + mrm;
    right = msum < 0;
    aup = right ? f.ar : f.al;
    if (aup == 0) aup = 1;
    mag = right ? longint'(-msum) : msum;
    adv = mul_shift(aup, mag, ausm_pkg::FRAC, right ? UMAX + 1 : UMAX);
    mlc = clip_unit(ml);
    mrc = clip_unit(mr);
    if (order == ausm_pkg::SPLIT_LINEAR) begin
      pp = mul_shift(f.pl, ONE + mlc, ausm_pkg::FRAC + 1, UMAX);
      pm = mul_shift(f.pr, ONE - mrc, ausm_pkg::FRAC + 1, UMAX);
    end else begin
      s = ONE + mlc;
      t = 2 * ONE - mlc;
      s2 = ONE - mrc;
      t2 = 2 * ONE + mrc;
      pp = mul_shift(f.pl, s * s * t, 3 * ausm_pkg::FRAC + 2, UMAX);
      pm = mul_shift(f.pr, s2 * s2 * t2, 3 * ausm_pkg::FRAC + 2, UMAX);
    end
    ph = pp + pm;
    if (ph > UMAX) ph = UMAX;
    r.vel = right ? W'(-adv) : W'(adv);
    r.pres = W'(ph);
    r.dens = right ? f.rr : f.rl;
    r.snd = right ? f.ar : f.al;
    r.tv = right ? f.vr : f.vl;
    r.tw = right ? f.wr : f.wl;
    r.lws = W'(clamp_s(ul - longint'(f.al)));
    r.rws = W'(clamp_s(ur + longint'(f.ar)));
    r.upr = right;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    flux_t e;
    if (rst_n && out_strobe) begin
      if (flux_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = flux_q.pop_front();
        n_checked++;
        if (got.vel !== e.vel) begin
          $error("interface_velocity exp %0d got %0d", e.vel, got.vel); errors++;
        end
        if (got.pres !== e.pres) begin
          $error("interface_pressure exp %0d got %0d", e.pres, got.pres); errors++;
        end
        if (got.dens !== e.dens) begin
          $error("interface_density exp %0d got %0d", e.dens, got.dens); errors++;
        end
        if (got.snd !== e.snd) begin
          $error("interface_sound_speed exp %0d got %0d", e.snd, got.snd); errors++;
        end
        if (got.tv !== e.tv) begin
          $error("interface_tangential_v exp %0d got %0d", e.tv, got.tv); errors++;
        end
        if (got.tw !== e.tw) begin
          $error("interface_tangential_w exp %0d got %0d", e.tw, got.tw); errors++;
        end
        if (got.lws !== e.lws) begin
          $error("left_wave_speed exp %0d got %0d", e.lws, got.lws); errors++;
        end
        if (got.rws !== e.rws) begin
          $error("right_wave_speed exp %0d got %0d", e.rws, got.rws); errors++;
        end
        if (got.upr !== e.upr) begin
          $error("upwind_is_right exp %0b got %0b", e.upr, got.upr); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_face(face_t f);
    drv <= f;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    flux_q.push_back(ausm_flux(f, split_order));
    n_items++;
    if (split_order == ausm_pkg::SPLIT_QUAD) n_quad++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // sender pauses until the pipeline is empty, then the order register is written
  task automatic drain_and_set(logic order);
    start <= 1'b0;
    while (flux_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= order;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_order = order;
  endtask

  function automatic logic [W-1:0] rand_bits();
    return W'({$urandom, $urandom});
  endfunction

  // sound speed and velocity around a chosen Mach number, bounded so most cases are physical
  function automatic face_t rand_face();
    face_t f;
    longint a;
    if ($urandom_range(0, 9) < 3) begin
      f.ul = rand_bits(); f.vl = rand_bits(); f.wl = rand_bits();
      f.al = (W-1)'(rand_bits()); f.pl = (W-1)'(rand_bits()); f.rl = (W-1)'(rand_bits());
      f.ur = rand_bits(); f.vr = rand_bits(); f.wr = rand_bits();
      f.ar = (W-1)'(rand_bits()); f.pr = (W-1)'(rand_bits()); f.rr = (W-1)'(rand_bits());
    end else begin
      f.vl = rand_bits(); f.wl = rand_bits(); f.vr = rand_bits(); f.wr = rand_bits();
      f.rl = (W-1)'(rand_bits() >> $urandom_range(0, 20));
      f.rr = (W-1)'(rand_bits() >> $urandom_range(0, 20));
      f.pl = (W-1)'(rand_bits() >> $urandom_range(0, 20));
      f.pr = (W-1)'(rand_bits() >> $urandom_range(0, 20));
      a = $urandom_range(0, 1 << 30);
      f.al = (W-1)'(a);
      f.ul = W'((a * (longint'($urandom_range(0, 1536)) - 768)) / 256);
      a = $urandom_range(0, 1 << 30);
      f.ar = (W-1)'(a);
      f.ur = W'((a * (longint'($urandom_range(0, 1536)) - 768)) / 256);
    end
    return f;
  endfunction

  function automatic face_t still_face();
    face_t f;
    f = '{default: '0};
    f.al = (W-1)'(ONE); f.ar = (W-1)'(ONE);
    f.pl = (W-1)'(100 * ONE); f.pr = (W-1)'(100 * ONE);
    f.rl = (W-1)'(ONE); f.rr = (W-1)'(2 * ONE);
    f.vl = 5; f.vr = -5; f.wl = 7; f.wr = -7;
    return f;
  endfunction

  task automatic test_directed();
    face_t f;
    f = still_face(); send_face(f);
    // sonic on each side
    f = still_face(); f.ul = W'(ONE); f.ur = W'(-ONE); send_face(f);
    f = still_face(); f.ul = W'(-ONE); f.ur = W'(ONE); send_face(f);
    // supersonic both ways
    f = still_face(); f.ul = W'(3 * ONE); f.ur = W'(3 * ONE); send_face(f);
    f = still_face(); f.ul = W'(-3 * ONE); f.ur = W'(-3 * ONE); send_face(f);
    // zero sound speed in the divider
    f = still_face(); f.al = 0; f.ar = 0; f.ul = 1; f.ur = -1; send_face(f);
    f = still_face(); f.al = 0; f.ar = 0; send_face(f);
    // huge Mach magnitudes and saturated wave speeds
    f = still_face(); f.ul = {1'b0, {(W-1){1'b1}}}; f.al = 1;
    f.ur = {1'b1, {(W-1){1'b0}}}; f.ar = 1; send_face(f);
    f = still_face(); f.ul = {1'b1, {(W-1){1'b0}}}; f.al = '1;
    f.ur = {1'b0, {(W-1){1'b1}}}; f.ar = '1; send_face(f);
    // pressure extremes
    f = still_face(); f.pl = '1; f.pr = '1; send_face(f);
    f = still_face(); f.pl = 0; f.pr = 0; send_face(f);
    f = still_face(); f.pl = '1; f.pr = '1; f.ul = W'(ONE / 2); f.ur = W'(-ONE / 2);
    send_face(f);
    // tiny negative Mach sum, velocity truncates near zero
    f = still_face(); f.ur = -4; f.ar = (W-1)'(ONE); send_face(f);
    f = still_face(); f.ur = -4; f.ar = 100; send_face(f);
    // large advective speed from full-scale velocity and sound speed
    f = still_face(); f.ul = {1'b0, {(W-1){1'b1}}}; f.al = '1; f.ur = 0; send_face(f);
    f = still_face(); f.ul = 0; f.ur = {1'b1, {(W-1){1'b0}}}; f.ar = '1; send_face(f);
    // all-ones and all-zero fields
    f = '{default: '1}; send_face(f);
    f = '{default: '0}; send_face(f);
  endtask

  task automatic test_random(int count);
    repeat (count) send_face(rand_face());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_and_set(ausm_pkg::SPLIT_QUAD);
    test_directed();
    test_random(200);
    drain_and_set(ausm_pkg::SPLIT_LINEAR);
    test_random(200);
    drain_and_set(ausm_pkg::SPLIT_QUAD);
    idle_on = 1'b0;
    test_random(220);
    start <= 1'b0;
    while (flux_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("sent %0d faces (%0d with quadratic pressure split), checked %0d results",
             n_items, n_quad, n_checked);
    $display("covered sonic, supersonic, zero sound speed, saturation and both split orders");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
